[rtl/tcc_pkg.sv]
package tcc_pkg;

  // Console commands
  typedef enum logic [2:0] {
    CMD_CHAR   = 3'd0,
    CMD_EOL    = 3'd1,
    CMD_SETPOS = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_HEX    = 3'd4,
    CMD_UDEC   = 3'd5,
    CMD_SDEC   = 3'd6
  } cmd_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_GLYPH = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_NONE  = 2'd2
  } kind_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_REFRESH_EN = 2'd0;
  localparam logic [1:0] CFG_FONT_FIRST = 2'd1;

  localparam int VALUE_W    = 32;
  localparam int BCD_DIGITS = 10;

  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_MINUS   = 8'd45;
  localparam logic [7:0] CODE_ZERO    = 8'd48;
  localparam logic [7:0] CODE_LETTER  = 8'd55;  // 'A' - 10

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MINUS,
    ST_DIGITS
  } state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  char_code;
    logic [31:0] value;
    logic [3:0]  pos_column;
    logic [2:0]  pos_row;
  } in_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] row;
    logic [6:0] pixel_column;
    logic [7:0] glyph;
    logic       refresh;
    logic       bad_position;
    logic       last;
  } out_rsp_t;

  // Control into the digit serializer
  typedef struct packed {
    logic              load;
    logic              hex;
    logic              shift;
    logic [VALUE_W-1:0] value;
  } dig_ctl_t;

  // Status from the digit serializer
  typedef struct packed {
    logic       ready;
    logic       last;
    logic [3:0] digit;
  } dig_sts_t;

endpackage

[rtl/tcc_digit_ser.sv]
module tcc_digit_ser (
  input  logic              clk,
  input  logic              rst_n,
  input  tcc_pkg::dig_ctl_t ctl,
  output tcc_pkg::dig_sts_t sts
);

  localparam int BCD_W = 4 * tcc_pkg::BCD_DIGITS;
  localparam int BCNT_W = $clog2(tcc_pkg::VALUE_W + 1);
  localparam int DCNT_W = $clog2(tcc_pkg::BCD_DIGITS + 1);

  logic [tcc_pkg::VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]            bcd_r, bcd_nxt, bcd_adj;
  logic [BCNT_W-1:0]           bit_cnt_r, bit_cnt_nxt;
  logic [DCNT_W-1:0]           dig_cnt_r, dig_cnt_nxt;

  // Add-3 correction on every BCD digit, one binary bit per cycle
  always_comb begin
    logic [3:0] nib;
    for (int i = 0; i < tcc_pkg::BCD_DIGITS; i++) begin
      nib = bcd_r[4*i +: 4];
      bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  always_comb begin
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    if (ctl.load) begin
      dig_cnt_nxt = DCNT_W'(tcc_pkg::BCD_DIGITS);
      if (ctl.hex) begin
        // hex nibbles are already digits
        bcd_nxt     = BCD_W'(ctl.value);
        bit_cnt_nxt = '0;
      end else begin
        bin_nxt     = ctl.value;
        bcd_nxt     = '0;
        bit_cnt_nxt = BCNT_W'(tcc_pkg::VALUE_W);
      end
    end else if (bit_cnt_r != '0) begin
      bcd_nxt     = {bcd_adj[BCD_W-2:0], bin_r[tcc_pkg::VALUE_W-1]};
      bin_nxt     = {bin_r[tcc_pkg::VALUE_W-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r - BCNT_W'(1);
    end else if (ctl.shift) begin
      bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
      dig_cnt_nxt = dig_cnt_r - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r <= '0;
      dig_cnt_r <= '0;
    end else begin
      bit_cnt_r <= bit_cnt_nxt;
      dig_cnt_r <= dig_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  // Most significant digit is presented first
  assign sts.ready = (bit_cnt_r == '0);
  assign sts.last  = (dig_cnt_r == DCNT_W'(1));
  assign sts.digit = bcd_r[BCD_W-1 -: 4];

endmodule

[rtl/text_console_cursor_engine_core.sv]
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   tcc_pkg::in_req_t  (one command)
// out_     output     out_valid/out_stall tcc_pkg::out_rsp_t (one glyph write or status)
// cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data (register write)
//
// Char, end line, set position, clear: one result each, registered on acceptance.
// Hex: load, then skip each leading zero, then emit one glyph per digit.
// Decimal: bit-serial binary-to-BCD conversion of the 32-bit value, then the same
// digit walk (up to 10 digits, plus a minus sign for signed negatives).
// Reset is synchronous: cursor 0,0, skip flag clear, refresh enable 1, font code 32.
// A stalled output holds the result register; conversion keeps running meanwhile.
module text_console_cursor_engine_core #(
  parameter int COLUMNS    = 16,
  parameter int ROWS       = 8,
  parameter int CELL_WIDTH = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tcc_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tcc_pkg::out_rsp_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [6:0]        cfg_data
);

  localparam logic [4:0] COLS_W = 5'(COLUMNS);
  localparam logic [3:0] ROWS_W = 4'(ROWS);
  localparam logic [6:0] CW_W   = 7'(CELL_WIDTH);

  tcc_pkg::state_t   state_r, state_nxt;
  logic [3:0]        col_r, col_nxt;
  logic [2:0]        row_r, row_nxt;
  logic              skip_r, skip_nxt;
  logic              started_r, started_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcc_pkg::out_rsp_t out_data_r, out_data_nxt;
  logic              refresh_en_r;
  logic [6:0]        font_first_r;

  tcc_pkg::dig_ctl_t dctl;
  tcc_pkg::dig_sts_t dsts;

  logic              out_free;
  logic              in_take;
  logic [7:0]        draw_code;
  logic [7:0]        draw_glyph;
  logic [4:0]        col_inc;
  logic              col_wrap;
  logic [3:0]        row_inc;
  logic [2:0]        row_line;
  logic [6:0]        draw_pcol;
  logic [7:0]        digit_code;

  tcc_digit_ser u_digits (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dctl),
    .sts   (dsts)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == tcc_pkg::ST_IDLE) && out_free);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Digit to character code
  assign digit_code = (dsts.digit < 4'd10) ? tcc_pkg::CODE_ZERO + {4'd0, dsts.digit}
                                           : tcc_pkg::CODE_LETTER + {4'd0, dsts.digit};

  // Shared draw path: glyph index and cursor advance
  always_comb begin
    case (state_r)
      tcc_pkg::ST_MINUS:  draw_code = tcc_pkg::CODE_MINUS;
      tcc_pkg::ST_DIGITS: draw_code = digit_code;
      default:            draw_code = in_data.char_code;
    endcase
  end

  assign draw_glyph = (!draw_code[7] && (draw_code[6:0] >= font_first_r))
                      ? {1'b0, draw_code[6:0] - font_first_r} : 8'd0;
  assign col_inc    = {1'b0, col_r} + 5'd1;
  assign col_wrap   = (col_inc >= COLS_W);
  assign row_inc    = {1'b0, row_r} + 4'd1;
  assign row_line   = (row_inc >= ROWS_W) ? 3'd0 : row_inc[2:0];
  assign draw_pcol  = 7'({3'd0, col_r} * CW_W);

  // Command sequencer
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    skip_nxt      = skip_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    dctl          = '0;

    case (state_r)
      tcc_pkg::ST_IDLE: begin
        if (in_take) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.kind = tcc_pkg::KIND_NONE;
          out_data_nxt.last = 1'b1;
          case (in_data.command)
            tcc_pkg::CMD_CHAR: begin
              out_data_nxt.refresh = refresh_en_r;
              if (in_data.char_code == tcc_pkg::CODE_NEWLINE) begin
                if (skip_r) begin
                  skip_nxt = 1'b0;
                end else begin
                  col_nxt = '0;
                  row_nxt = row_line;
                end
              end else begin
                out_data_nxt.kind         = tcc_pkg::KIND_GLYPH;
                out_data_nxt.row          = row_r;
                out_data_nxt.pixel_column = draw_pcol;
                out_data_nxt.glyph        = draw_glyph;
                col_nxt  = col_wrap ? 4'd0 : col_inc[3:0];
                row_nxt  = col_wrap ? row_line : row_r;
                skip_nxt = col_wrap;
              end
            end
            tcc_pkg::CMD_EOL: begin
              if (skip_r) begin
                skip_nxt = 1'b0;
              end else begin
                col_nxt = '0;
                row_nxt = row_line;
              end
            end
            tcc_pkg::CMD_SETPOS: begin
              if (({1'b0, in_data.pos_column} < COLS_W) &&
                  ({1'b0, in_data.pos_row} < ROWS_W)) begin
                col_nxt = in_data.pos_column;
                row_nxt = in_data.pos_row;
              end else begin
                out_data_nxt.bad_position = 1'b1;
              end
            end
            tcc_pkg::CMD_CLEAR: begin
              out_data_nxt.kind    = tcc_pkg::KIND_CLEAR;
              out_data_nxt.refresh = refresh_en_r;
              col_nxt = '0;
              row_nxt = '0;
            end
            tcc_pkg::CMD_HEX, tcc_pkg::CMD_UDEC, tcc_pkg::CMD_SDEC: begin
              // Number: results come later from the digit walk
              out_valid_nxt = out_valid_r && out_stall;
              out_data_nxt  = out_data_r;
              started_nxt   = 1'b0;
              dctl.load     = 1'b1;
              dctl.hex      = (in_data.command == tcc_pkg::CMD_HEX);
              dctl.value    = in_data.value;
              state_nxt     = tcc_pkg::ST_DIGITS;
              if ((in_data.command == tcc_pkg::CMD_SDEC) && in_data.value[31]) begin
                dctl.value = ~in_data.value + 32'd1;
                state_nxt  = tcc_pkg::ST_MINUS;
              end
            end
            default: begin
            end
          endcase
        end
      end

      tcc_pkg::ST_MINUS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.kind         = tcc_pkg::KIND_GLYPH;
          out_data_nxt.row          = row_r;
          out_data_nxt.pixel_column = draw_pcol;
          out_data_nxt.glyph        = draw_glyph;
          col_nxt   = col_wrap ? 4'd0 : col_inc[3:0];
          row_nxt   = col_wrap ? row_line : row_r;
          skip_nxt  = col_wrap;
          state_nxt = tcc_pkg::ST_DIGITS;
        end
      end

      tcc_pkg::ST_DIGITS: begin
        if (dsts.ready) begin
          if (!started_r && (dsts.digit == 4'd0) && !dsts.last) begin
            // leading zero
            dctl.shift = 1'b1;
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_data_nxt.kind         = tcc_pkg::KIND_GLYPH;
            out_data_nxt.row          = row_r;
            out_data_nxt.pixel_column = draw_pcol;
            out_data_nxt.glyph        = draw_glyph;
            out_data_nxt.last         = dsts.last;
            out_data_nxt.refresh      = dsts.last && refresh_en_r;
            col_nxt     = col_wrap ? 4'd0 : col_inc[3:0];
            row_nxt     = col_wrap ? row_line : row_r;
            skip_nxt    = col_wrap;
            started_nxt = 1'b1;
            dctl.shift  = 1'b1;
            if (dsts.last) begin
              state_nxt = tcc_pkg::ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = tcc_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcc_pkg::ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      skip_r      <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      skip_r      <= skip_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_en_r <= 1'b1;
      font_first_r <= 7'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcc_pkg::CFG_REFRESH_EN: refresh_en_r <= cfg_data[0];
        tcc_pkg::CFG_FONT_FIRST: font_first_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Single-result commands have their result registered on acceptance and stay idle
  a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && (in_data.command != tcc_pkg::CMD_HEX) &&
     (in_data.command != tcc_pkg::CMD_UDEC) && (in_data.command != tcc_pkg::CMD_SDEC))
    |=> (state_r == tcc_pkg::ST_IDLE) && out_valid_r && out_data_r.last)
    else $error("single-result command did not complete");

  // Non-glyph results only ever end a command
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.kind != tcc_pkg::KIND_GLYPH)) |-> out_data_r.last)
    else $error("status result without last");

  // Minus sign is always followed by the digit walk
  a_minus_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcc_pkg::ST_MINUS) |=>
    ((state_r == tcc_pkg::ST_MINUS) || (state_r == tcc_pkg::ST_DIGITS)))
    else $error("bad sequence after minus sign");

  // Leaving the digit walk means a last result was just loaded
  a_digits_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == tcc_pkg::ST_DIGITS) && (state_nxt == tcc_pkg::ST_IDLE))
    |=> out_valid_r && out_data_r.last)
    else $error("digit walk ended without last result");

endmodule

[tb/tcc_checker.sv]
module tcc_checker #(
  parameter int COLUMNS    = 16,
  parameter int ROWS       = 8,
  parameter int CELL_WIDTH = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  tcc_pkg::in_req_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  tcc_pkg::out_rsp_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  output int                errors,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the console state and registers
  int         cur_col;
  int         cur_row;
  logic       skip_nl;
  logic       refresh_en;
  logic [6:0] first_code;

  // Writes predicted but not yet seen on the result channel, oldest first
  tcc_pkg::out_rsp_t pending_writes[$];
  int                mismatches = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report(what, got, want);
  endtask

  task automatic push_write(input tcc_pkg::kind_t k, input int row, input int pcol,
                            input logic [7:0] g, input logic bad);
    tcc_pkg::out_rsp_t w;
    w.kind         = k;
    w.row          = 3'(row);
    w.pixel_column = 7'(pcol);
    w.glyph        = g;
    w.refresh      = 1'b0;
    w.bad_position = bad;
    w.last         = 1'b0;
    pending_writes.push_back(w);
  endtask

  task automatic advance_row();
    cur_row = (cur_row == ROWS - 1) ? 0 : cur_row + 1;
  endtask

  // A newline right after a wrap at the right edge only clears the flag
  task automatic line_break();
    if (skip_nl) begin
      skip_nl = 1'b0;
    end else begin
      cur_col = 0;
      advance_row();
    end
  endtask

  // One glyph write at the cursor, then move right with wrap
  task automatic emit_glyph(input logic [7:0] code);
    logic [7:0] g;
    g = 8'd0;
    if (code < 8'd128 && code >= 8'(first_code)) g = code - 8'(first_code);
    push_write(tcc_pkg::KIND_GLYPH, cur_row, cur_col * CELL_WIDTH, g, 1'b0);
    if (cur_col == COLUMNS - 1) begin
      cur_col = 0;
      advance_row();
      skip_nl = 1'b1;
    end else begin
      cur_col = cur_col + 1;
      skip_nl = 1'b0;
    end
  endtask

  // Digits most significant first, no leading zeros
  task automatic emit_number(input logic [31:0] v, input int unsigned base);
    logic [7:0]  digs[10];
    logic [31:0] d;
    int          n;
    n = 0;
    do begin
      d       = v % base;
      digs[n] = (d < 10) ? tcc_pkg::CODE_ZERO + 8'(d) : tcc_pkg::CODE_LETTER + 8'(d);
      n++;
      v = v / base;
    end while (v != 0 && n < 10);
    while (n > 0) begin
      n--;
      emit_glyph(digs[n]);
    end
  endtask

  // All writes caused by one command; refresh and last go on the final one
  task automatic console_step(input tcc_pkg::in_req_t req);
    tcc_pkg::out_rsp_t tail;
    logic              rf;
    logic [31:0]       mag;
    rf = 1'b0;
    case (req.command)
      tcc_pkg::CMD_CHAR: begin
        rf = refresh_en;
        if (req.char_code == tcc_pkg::CODE_NEWLINE) begin
          line_break();
          push_write(tcc_pkg::KIND_NONE, 0, 0, 8'd0, 1'b0);
        end else begin
          emit_glyph(req.char_code);
        end
      end
      tcc_pkg::CMD_EOL: begin
        line_break();
        push_write(tcc_pkg::KIND_NONE, 0, 0, 8'd0, 1'b0);
      end
      tcc_pkg::CMD_SETPOS: begin
        if (req.pos_column < COLUMNS && req.pos_row < ROWS) begin
          cur_col = int'(req.pos_column);
          cur_row = int'(req.pos_row);
          push_write(tcc_pkg::KIND_NONE, 0, 0, 8'd0, 1'b0);
        end else begin
          push_write(tcc_pkg::KIND_NONE, 0, 0, 8'd0, 1'b1);
        end
      end
      tcc_pkg::CMD_CLEAR: begin
        cur_col = 0;
        cur_row = 0;
        rf      = refresh_en;
        push_write(tcc_pkg::KIND_CLEAR, 0, 0, 8'd0, 1'b0);
      end
      tcc_pkg::CMD_HEX: begin
        rf = refresh_en;
        emit_number(req.value, 16);
      end
      tcc_pkg::CMD_UDEC: begin
        rf = refresh_en;
        emit_number(req.value, 10);
      end
      tcc_pkg::CMD_SDEC: begin
        rf  = refresh_en;
        mag = req.value;
        if (mag[31]) begin
          emit_glyph(tcc_pkg::CODE_MINUS);
          mag = ~mag + 32'd1;
        end
        emit_number(mag, 10);
      end
      default: push_write(tcc_pkg::KIND_NONE, 0, 0, 8'd0, 1'b0);
    endcase
    tail         = pending_writes.pop_back();
    tail.refresh = rf;
    tail.last    = 1'b1;
    pending_writes.push_back(tail);
  endtask

  // Watch all three channels at the clock edge
  always @(posedge clk) begin
    tcc_pkg::out_rsp_t want;
    if (!rst_n) begin
      cur_col    = 0;
      cur_row    = 0;
      skip_nl    = 1'b0;
      refresh_en = 1'b1;
      first_code = 7'd32;
      pending_writes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcc_pkg::CFG_REFRESH_EN: refresh_en = cfg_data[0];
          tcc_pkg::CFG_FONT_FIRST: first_code = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) console_step(in_data);
      if (out_valid && !out_stall) begin
        if (pending_writes.size() == 0) begin
          report("unrequested result kind", 32'(out_data.kind), 32'd0);
        end else begin
          want = pending_writes.pop_front();
          check_field("kind", 32'(out_data.kind), 32'(want.kind));
          check_field("row", 32'(out_data.row), 32'(want.row));
          check_field("pixel_column", 32'(out_data.pixel_column),
                      32'(want.pixel_column));
          check_field("glyph", 32'(out_data.glyph), 32'(want.glyph));
          check_field("refresh", 32'(out_data.refresh), 32'(want.refresh));
          check_field("bad_position", 32'(out_data.bad_position),
                      32'(want.bad_position));
          check_field("last", 32'(out_data.last), 32'(want.last));
        end
      end
    end
    errors      <= mismatches;
    outstanding <= pending_writes.size();
  end

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS     = 16;
  localparam int ROWS        = 8;
  localparam int CELL_WIDTH  = 6;
  localparam int CYCLE_LIMIT = 200000;
  // command code the package leaves unassigned
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  tcc_pkg::in_req_t  in_data;
  logic              out_valid;
  logic              out_stall;
  tcc_pkg::out_rsp_t out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [6:0]        cfg_data;
  int                errors;
  int                outstanding;
  int                cycle_count = 0;
  logic              steady = 1'b0;

  text_console_cursor_engine_core #(
    .COLUMNS(COLUMNS), .ROWS(ROWS), .CELL_WIDTH(CELL_WIDTH)
  ) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tcc_checker #(
    .COLUMNS(COLUMNS), .ROWS(ROWS), .CELL_WIDTH(CELL_WIDTH)
  ) i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stall before taking each result
  initial begin : result_drain
    int n;
    out_stall <= 1'b0;
    forever begin
      n = steady ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic tcc_pkg::in_req_t make_req(input logic [2:0] cmd,
                                                input logic [7:0] code,
                                                input logic [31:0] value,
                                                input logic [3:0] col,
                                                input logic [2:0] row);
    tcc_pkg::in_req_t r;
    r.command    = cmd;
    r.char_code  = code;
    r.value      = value;
    r.pos_column = col;
    r.pos_row    = row;
    return r;
  endfunction

  // Issue one request after a random gap and hold it until taken
  task automatic send_cmd(input tcc_pkg::in_req_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every predicted result has come out
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_config(input logic refresh_on, input logic [6:0] first);
    cfg_valid <= 1'b1;
    cfg_index <= tcc_pkg::CFG_REFRESH_EN;
    cfg_data  <= {6'd0, refresh_on};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= tcc_pkg::CFG_FONT_FIRST;
    cfg_data  <= first;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    tcc_pkg::in_req_t req;
    int               pick;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= tcc_pkg::CFG_REFRESH_EN;
    cfg_data  <= 7'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset register values first
    send_cmd(make_req(tcc_pkg::CMD_CHAR, 8'd65, 32'd0, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_CHAR, 8'd0, 32'd0, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_CHAR, 8'd255, 32'd0, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_CHAR, 8'd127, 32'd0, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_CHAR, 8'd31, 32'd0, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_CHAR, tcc_pkg::CODE_NEWLINE, 32'd0, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_EOL, 8'd0, 32'd0, 4'd0, 3'd0));
    // wrap at the bottom right corner, then a newline that is swallowed
    send_cmd(make_req(tcc_pkg::CMD_SETPOS, 8'd0, 32'd0, 4'd15, 3'd7));
    send_cmd(make_req(tcc_pkg::CMD_CHAR, 8'd90, 32'd0, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_CHAR, tcc_pkg::CODE_NEWLINE, 32'd0, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_EOL, 8'd0, 32'd0, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_SETPOS, 8'd0, 32'd0, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_HEX, 8'd0, 32'd0, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_HEX, 8'd0, 32'hFFFF_FFFF, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_UDEC, 8'd0, 32'd0, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_UDEC, 8'd0, 32'hFFFF_FFFF, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_SDEC, 8'd0, 32'h8000_0000, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_SDEC, 8'd0, 32'hFFFF_FFFF, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_SDEC, 8'd0, 32'h7FFF_FFFF, 4'd0, 3'd0));
    // number that wraps partway through
    send_cmd(make_req(tcc_pkg::CMD_SETPOS, 8'd0, 32'd0, 4'd13, 3'd7));
    send_cmd(make_req(tcc_pkg::CMD_UDEC, 8'd0, 32'd12345, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_CLEAR, 8'd0, 32'd0, 4'd0, 3'd0));
    send_cmd(make_req(CMD_UNUSED, 8'd0, 32'd0, 4'd0, 3'd0));

    wait_drained(10);
    set_config(1'b0, 7'd0);
    send_cmd(make_req(tcc_pkg::CMD_CHAR, 8'd0, 32'd0, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_CHAR, 8'd127, 32'd0, 4'd0, 3'd0));
    send_cmd(make_req(tcc_pkg::CMD_HEX, 8'd0, 32'h1234_5678, 4'd0, 3'd0));

    // Random phases, each under its own register setting
    for (int seg = 0; seg < 7; seg++) begin
      wait_drained(10);
      case (seg)
        0: set_config(1'b1, 7'd127);
        1: set_config(1'b0, 7'd32);
        2: set_config(1'b1, 7'd0);
        3: set_config(1'b0, 7'd48);
        4: set_config(1'b1, 7'($urandom_range(0, 127)));
        5: set_config(1'b0, 7'd65);
        default: set_config(1'b1, 7'd32);
      endcase
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 27; k++) begin
        if (k == 15 && $urandom_range(0, 2) == 0) wait_drained(0);
        // unused fields carry noise
        req.char_code  = 8'($urandom_range(0, 255));
        req.value      = $urandom();
        req.pos_column = 4'($urandom_range(0, 15));
        req.pos_row    = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          req.command = tcc_pkg::CMD_CHAR;
          case ($urandom_range(0, 7))
            0: req.char_code = tcc_pkg::CODE_NEWLINE;
            1, 2: ;
            default: req.char_code = 8'($urandom_range(32, 126));
          endcase
        end else begin
          // about half the numbers are shortened, the rest keep full width
          case ($urandom_range(0, 3))
            0: req.value = req.value >> $urandom_range(1, 31);
            1: req.value = req.value >> $urandom_range(20, 31);
            default: ;
          endcase
          if (pick < 52) req.command = tcc_pkg::CMD_HEX;
          else if (pick < 64) req.command = tcc_pkg::CMD_UDEC;
          else if (pick < 76) req.command = tcc_pkg::CMD_SDEC;
          else if (pick < 86) begin
            req.command = tcc_pkg::CMD_SETPOS;
            if ($urandom_range(0, 1) == 1) req.pos_column = 4'($urandom_range(12, 15));
          end
          else if (pick < 93) req.command = tcc_pkg::CMD_EOL;
          else if (pick < 96) req.command = tcc_pkg::CMD_CLEAR;
          else req.command = CMD_UNUSED;
        end
        send_cmd(req);
      end
    end

    wait_drained(60);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
